// File: rtl/assert_macros.svh
// Assertion helpers, included by the deframer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define PSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: lbl");

// Checked on every clock edge, reset included.
`define PSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed: lbl");

`else

`define PSD_ASSERT(lbl, clk, rst, prop)
`define PSD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/psd_pkg.sv
`default_nettype none

package psd_pkg;

  // Parsing phase
  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_BAND = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_CLEAN      = 2'd1,
    KIND_BAD        = 2'd2,
    KIND_REMOTE_ERR = 2'd3
  } kind_t;

  // Sideband codes
  localparam logic [1:0] BAND_OTHER    = 2'd0;
  localparam logic [1:0] BAND_DATA     = 2'd1;
  localparam logic [1:0] BAND_PROGRESS = 2'd2;
  localparam logic [1:0] BAND_ERROR    = 2'd3;

  localparam logic [7:0]  BAND_BYTE_MIN   = 8'd1;
  localparam logic [7:0]  BAND_BYTE_MAX   = 8'd3;
  localparam logic [15:0] HDR_LEN         = 16'd4;
  localparam logic [1:0]  LEN_DIGIT_LAST  = 2'd3;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  digit_count;
    logic [15:0] length_accum;
    logic [15:0] bytes_left;
    logic [1:0]  current_band;
    logic        finished;
  } psd_state_t;

  localparam psd_state_t PSD_STATE_RESET = '{
    phase:        PH_LEN,
    digit_count:  2'd0,
    length_accum: 16'd0,
    bytes_left:   16'd0,
    current_band: BAND_OTHER,
    finished:     1'b0
  };

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // ASCII hex digit, either case
  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: rtl/psd_stream_if.sv
`default_nettype none

// Raw framed byte stream
interface psd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// Demultiplexed result stream
interface psd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;

  modport source (output valid, output out_byte, output out_kind, input ready);
  modport sink   (input valid, input out_byte, input out_kind, output ready);
endinterface

`default_nettype wire

// File: rtl/pkt_line_sideband_deframer_top.sv
// Each result is registered and appears on the output in the cycle after the input beat that causes it.
// Throughput: one input beat per cycle, limited only by the single output register.
// Input is taken while the output register is empty or is being drained in the same cycle.
// Reset (rst, synchronous, active high) returns the parser to the length-digit phase
// and empties the output register; no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module pkt_line_sideband_deframer_top (
  input  var logic  clk,
  input  var logic  rst,
  psd_in_if.sink    in_ch,
  psd_out_if.source out_ch
);

  // Parser state, advanced on every accepted input beat
  psd_pkg::psd_state_t st;
  psd_pkg::psd_state_t st_next;

  // Combinational result of the current input beat
  logic           res_valid;
  psd_pkg::kind_t res_kind;
  logic [7:0]     res_byte;

  // Output register
  logic           out_valid;
  psd_pkg::kind_t out_kind;
  logic [7:0]     out_byte;

  logic in_fire;
  logic end_fire;

  // A beat may enter whenever the output register will be free at the next edge.
  // A result held by a stalled sink stops every input beat, even one that
  // would produce nothing.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign end_fire    = in_fire && res_valid && (res_kind != psd_pkg::KIND_DATA);

  psd_step u_step (
    .cur           (st),
    .data_byte     (in_ch.data_byte),
    .end_of_stream (in_ch.end_of_stream),
    .nxt           (st_next),
    .res_valid     (res_valid),
    .res_kind      (res_kind),
    .res_byte      (res_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= psd_pkg::PSD_STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        st <= st_next;
      end
      if (in_fire && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload needs no reset; it is qualified by out_valid
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_kind <= res_kind;
      out_byte <= res_byte;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.out_kind = out_kind;
  assign out_ch.out_byte = out_byte;

  // Once the stream is over nothing more is produced
  `PSD_ASSERT(a_quiet_after_end, clk, rst, (in_fire && st.finished) |-> !res_valid)

  // Any terminal result marks the stream finished
  `PSD_ASSERT(a_end_sets_finished, clk, rst, end_fire |=> st.finished)

  // The band phase always holds a positive byte budget
  `PSD_ASSERT(a_band_has_budget, clk, rst, (st.phase == psd_pkg::PH_BAND) |-> (st.bytes_left != 16'd0))

  // Only data results carry a byte
  `PSD_ASSERT(a_byte_zero_on_end, clk, rst, (out_valid && out_kind != psd_pkg::KIND_DATA) |-> (out_byte == 8'd0))

endmodule

`default_nettype wire

// File: rtl/psd_step.sv
`default_nettype none

// Next-state and result logic for one input beat.
module psd_step (
  input  var psd_pkg::psd_state_t cur,
  input  var logic [7:0]          data_byte,
  input  var logic                end_of_stream,
  output psd_pkg::psd_state_t     nxt,
  output logic                    res_valid,
  output psd_pkg::kind_t          res_kind,
  output logic [7:0]              res_byte
);

  psd_pkg::hex_t hex;
  logic [15:0]   left_dec;
  logic [15:0]   accum_new;
  logic [1:0]    band;

  assign hex       = psd_pkg::hex_value(data_byte);
  assign left_dec  = cur.bytes_left - 16'd1;
  assign accum_new = {cur.length_accum[11:0], hex.val};

  always_comb begin
    band = psd_pkg::BAND_OTHER;
    if (data_byte inside {[psd_pkg::BAND_BYTE_MIN:psd_pkg::BAND_BYTE_MAX]}) begin
      band = data_byte[1:0];
    end
  end

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res_kind  = psd_pkg::KIND_DATA;
    res_byte  = 8'd0;
    if (cur.finished) begin
      // stream over: swallow everything
    end else if (end_of_stream) begin
      nxt.finished = 1'b1;
      res_valid    = 1'b1;
      if (cur.phase != psd_pkg::PH_BAND && cur.phase != psd_pkg::PH_BODY &&
          cur.digit_count == 2'd0) begin
        res_kind = psd_pkg::KIND_CLEAN;
      end else begin
        res_kind = psd_pkg::KIND_BAD;
      end
    end else begin
      case (cur.phase)
        psd_pkg::PH_BAND: begin
          nxt.current_band = band;
          nxt.bytes_left   = left_dec;
          if (left_dec == 16'd0) begin
            nxt.phase = psd_pkg::PH_LEN;
            if (band == psd_pkg::BAND_ERROR) begin
              nxt.finished = 1'b1;
              res_valid    = 1'b1;
              res_kind     = psd_pkg::KIND_REMOTE_ERR;
            end
          end else begin
            nxt.phase = psd_pkg::PH_BODY;
          end
        end
        psd_pkg::PH_BODY: begin
          nxt.bytes_left = left_dec;
          if (left_dec == 16'd0) begin
            nxt.phase = psd_pkg::PH_LEN;
          end
          if (left_dec == 16'd0 && cur.current_band == psd_pkg::BAND_ERROR) begin
            nxt.finished = 1'b1;
            res_valid    = 1'b1;
            res_kind     = psd_pkg::KIND_REMOTE_ERR;
          end else if (cur.current_band == psd_pkg::BAND_DATA) begin
            res_valid = 1'b1;
            res_kind  = psd_pkg::KIND_DATA;
            res_byte  = data_byte;
          end
        end
        default: begin
          // length digits; the spare phase code behaves the same
          if (!hex.ok) begin
            nxt.finished = 1'b1;
            res_valid    = 1'b1;
            res_kind     = psd_pkg::KIND_BAD;
          end else if (cur.digit_count != psd_pkg::LEN_DIGIT_LAST) begin
            nxt.digit_count  = cur.digit_count + 2'd1;
            nxt.length_accum = accum_new;
            nxt.phase        = psd_pkg::PH_LEN;
          end else begin
            nxt.digit_count  = 2'd0;
            nxt.length_accum = 16'd0;
            nxt.phase        = psd_pkg::PH_LEN;
            if (accum_new == 16'd0 || accum_new == psd_pkg::HDR_LEN) begin
              // empty packet
            end else if (accum_new < psd_pkg::HDR_LEN) begin
              nxt.finished = 1'b1;
              res_valid    = 1'b1;
              res_kind     = psd_pkg::KIND_BAD;
            end else begin
              nxt.bytes_left = accum_new - psd_pkg::HDR_LEN;
              nxt.phase      = psd_pkg::PH_BAND;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire
